// File: sv/u2l_pkg.sv
// Package with shared types, constants and the transliteration table.
package u2l_pkg;

    localparam logic [7:0] REPL_CHAR  = 8'h3F;
    localparam int         QUEUE_DEPTH = 2;

    // Work command passed from the decoder to the emitter.
    typedef struct packed {
        logic        has_char;   // a final character follows the replacements
        logic [20:0] code;       // code point to translate when has_char
        logic [2:0]  repl_cnt;   // number of '?' emitted before the character
    } u2l_cmd_t;

    // Translate a code point to Latin-1; '?' on a miss.
    function automatic logic [7:0] rom_lookup(input logic [20:0] cp);
        logic [7:0] c;
        c = REPL_CHAR;
        if (cp <= 21'h0000FF)
        begin
            c = cp[7:0];
        end
        else if (cp >= 21'h000100 && cp <= 21'h00017F)
        begin
            c = latin_ext_a(cp[6:0]);
        end
        else if (cp >= 21'h000410 && cp <= 21'h000425)
        begin
            c = cyr_letter(5'(cp - 21'h000410), 1'b1);
        end
        else if (cp >= 21'h000430 && cp <= 21'h000445)
        begin
            c = cyr_letter(5'(cp - 21'h000430), 1'b0);
        end
        else
        begin
            unique case (cp)
                21'h2010, 21'h2011, 21'h2012, 21'h2013, 21'h2014, 21'h2212: c = 8'h2D;
                21'h2018, 21'h2019: c = 8'h27;
                21'h201C, 21'h201D: c = 8'h22;
                21'h2022: c = 8'h2A;
                21'h2026: c = 8'h2E;
                21'h20AC: c = 8'h45;
                default:  c = REPL_CHAR;
            endcase
        end
        return c;
    endfunction

    // Latin Extended-A, U+0100 to U+017F.
    function automatic logic [7:0] latin_ext_a(input logic [6:0] idx);
        logic [8*128-1:0] tbl;
        logic [7:0]       c;
        tbl = {"AaAaAaCcCcCcCcDd", "DdEeEeEeEeEeGgGg", "GgGgHhHhIiIiIiIi",
               "Ii~~JjKk~LlLlLl~", "~LlNnNnNn~~~OoOo", "Oo~~RrRrRrSsSsSs",
               "SsTtTtTtUuUuUuUu", "UuUuWwYyYZzZzZz~"};
        c = tbl[8*(127 - int'(idx)) +: 8];
        return (c == 8'h7E) ? REPL_CHAR : c;
    endfunction

    // Cyrillic letters A to Kha in upper or lower case.
    function automatic logic [7:0] cyr_letter(input logic [4:0] idx, input logic upper);
        logic [8*22-1:0] tbl;
        logic [7:0]      c;
        tbl = "ABVGDE~~~~K~MNOPRSTU~X";
        c = REPL_CHAR;
        if (idx < 5'd22)
        begin
            c = tbl[8*(21 - int'(idx)) +: 8];
        end
        if (c == 8'h7E)
        begin
            c = REPL_CHAR;
        end
        else if (!upper && c != REPL_CHAR)
        begin
            c = c | 8'h20;
        end
        return c;
    endfunction

endpackage

// File: sv/u2l_stream_if.sv
// Valid/ready stream interface carrying one payload.
interface u2l_stream_if #(parameter type payload_t = logic [7:0]);
    logic     valid;
    logic     ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: sv/utf8_to_latin1_transliterator_unit.sv
// Top level of the UTF-8 to Latin-1 transliterator.
//   channel  | dir | payload                 | transfer
//   in_ch    | in  | in_byte, end_of_text    | valid && ready
//   out_ch   | out | out_char, run_last      | valid && ready
// One byte is taken per cycle while the command queue has room.
// Each byte gives up to four characters; the emitter sends one per cycle while
// the output is ready, so a byte with several results holds the queue head until all are sent.
// A byte's first character passes through the queue entry, then the output register.
// Reset clears sequence state, queue and output valid; no clearing pass.
// Input and output stall independently through the two-entry queue.
module utf8_to_latin1_transliterator_unit
(
    input logic clk,
    input logic rst_n,
    u2l_stream_if.sink   in_ch,
    u2l_stream_if.source out_ch
);

    logic              dq_valid, dq_ready, qe_valid, qe_ready;
    u2l_pkg::u2l_cmd_t dq_cmd, qe_cmd;

    u2l_decoder u_dec (
        .clk, .rst_n,
        .in_valid(in_ch.valid), .in_ready(in_ch.ready),
        .in_byte(in_ch.data.in_byte), .end_of_text(in_ch.data.end_of_text),
        .cmd_valid(dq_valid), .cmd_ready(dq_ready), .cmd(dq_cmd)
    );

    u2l_cmd_queue u_q (
        .clk, .rst_n,
        .wr_valid(dq_valid), .wr_ready(dq_ready), .wr_data(dq_cmd),
        .rd_valid(qe_valid), .rd_ready(qe_ready), .rd_data(qe_cmd)
    );

    u2l_emitter u_emit (
        .clk, .rst_n,
        .cmd_valid(qe_valid), .cmd_ready(qe_ready), .cmd(qe_cmd),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready),
        .out_char(out_ch.data.out_char), .run_last(out_ch.data.run_last)
    );

endmodule

// File: sv/u2l_decoder.sv
// Front end: UTF-8 sequence state and command generation, one byte per cycle while cmd_ready is high.
module u2l_decoder
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           in_byte,
    input  logic                 end_of_text,
    output logic                 cmd_valid,
    input  logic                 cmd_ready,
    output u2l_pkg::u2l_cmd_t    cmd
);

    logic [2:0]  seq_length_reg, seq_length_next;
    logic [1:0]  bytes_held_reg, bytes_held_next;
    logic [20:0] code_accum_reg, code_accum_next;
    logic        fire;

    assign in_ready = cmd_ready;
    assign fire     = in_valid && in_ready;

    // Decode one byte into next state and a command.
    always_comb
    begin
        logic [2:0] repl;
        logic       fresh;
        logic [1:0] held_inc;
        seq_length_next = seq_length_reg;
        bytes_held_next = bytes_held_reg;
        code_accum_next = code_accum_reg;
        cmd             = '0;
        repl            = 3'd0;
        fresh           = 1'b0;
        held_inc        = bytes_held_reg + 2'd1;
        if (seq_length_reg == 3'd0)
        begin
            fresh = 1'b1;
        end
        else if (in_byte[7:6] == 2'b10)
        begin
            code_accum_next = {code_accum_reg[14:0], in_byte[5:0]};
            bytes_held_next = held_inc;
            if ({1'b0, held_inc} + 3'd1 >= seq_length_reg)
            begin
                cmd.has_char    = 1'b1;
                cmd.code        = code_accum_next;
                seq_length_next = 3'd0;
                bytes_held_next = 2'd0;
                code_accum_next = '0;
            end
        end
        else
        begin
            repl  = {1'b0, bytes_held_reg} + 3'd1;
            fresh = 1'b1;
        end
        if (fresh)
        begin
            seq_length_next = 3'd0;
            bytes_held_next = 2'd0;
            code_accum_next = '0;
            priority if (!in_byte[7])
            begin
                cmd.has_char = 1'b1;
                cmd.code     = {13'd0, in_byte};
            end
            else if (in_byte[7:5] == 3'b110)
            begin
                seq_length_next = 3'd2;
                code_accum_next = {16'd0, in_byte[4:0]};
            end
            else if (in_byte[7:4] == 4'b1110)
            begin
                seq_length_next = 3'd3;
                code_accum_next = {17'd0, in_byte[3:0]};
            end
            else if (in_byte[7:3] == 5'b11110)
            begin
                seq_length_next = 3'd4;
                code_accum_next = {18'd0, in_byte[2:0]};
            end
            else
            begin
                repl = repl + 3'd1;
            end
        end
        // End of text flushes a sequence left open.
        if (end_of_text && seq_length_next != 3'd0)
        begin
            repl            = repl + {1'b0, bytes_held_next} + 3'd1;
            seq_length_next = 3'd0;
            bytes_held_next = 2'd0;
            code_accum_next = '0;
        end
        cmd.repl_cnt = repl;
    end

    assign cmd_valid = fire && (cmd.has_char || cmd.repl_cnt != 3'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_length_reg <= '0;
            bytes_held_reg <= '0;
            code_accum_reg <= '0;
        end
        else if (fire)
        begin
            seq_length_reg <= seq_length_next;
            bytes_held_reg <= bytes_held_next;
            code_accum_reg <= code_accum_next;
        end
    end

    ap_held_lt_len: assert property (@(posedge clk) disable iff (!rst_n)
        seq_length_reg != 3'd0 |-> {1'b0, bytes_held_reg} + 3'd1 < seq_length_reg)
        else $error("held count reached sequence length");
    ap_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
        seq_length_reg == 3'd0 |-> bytes_held_reg == 2'd0 && code_accum_reg == '0)
        else $error("state not cleared with no sequence open");
    ap_cmd_fire: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid |-> fire)
        else $error("command without accepted byte");

endmodule

// File: sv/u2l_cmd_queue.sv
// Two-entry queue between decoder and emitter.
module u2l_cmd_queue
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_valid,
    output logic              wr_ready,
    input  u2l_pkg::u2l_cmd_t wr_data,
    output logic              rd_valid,
    input  logic              rd_ready,
    output u2l_pkg::u2l_cmd_t rd_data
);

    u2l_pkg::u2l_cmd_t mem_reg [u2l_pkg::QUEUE_DEPTH];
    logic              wptr_reg, rptr_reg;
    logic [1:0]        count_reg;
    logic              push, pop;

    assign wr_ready = count_reg != 2'(u2l_pkg::QUEUE_DEPTH);
    assign rd_valid = count_reg != 2'd0;
    assign rd_data  = mem_reg[rptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    // Storage write.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= wr_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= ~wptr_reg;
            end
            if (pop)
            begin
                rptr_reg <= ~rptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

    ap_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'(u2l_pkg::QUEUE_DEPTH))
        else $error("queue overflow");
    ap_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd0 || count_reg == 2'd2) |-> wptr_reg == rptr_reg)
        else $error("pointers disagree with count");
    ap_push_pop: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> count_reg == $past(count_reg) + 2'd1)
        else $error("count did not grow on push");

endmodule

// File: sv/u2l_emitter.sv
// Back end: expands commands into output characters with a registered output.
module u2l_emitter
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  u2l_pkg::u2l_cmd_t cmd,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [7:0]        out_char,
    output logic              run_last
);

    logic [2:0] done_reg;
    logic       valid_reg;
    logic [7:0] char_reg;
    logic       last_reg;
    logic       load;
    logic [2:0] total;
    logic [2:0] done_inc;

    assign total     = cmd.repl_cnt + 3'(cmd.has_char);
    assign done_inc  = done_reg + 3'd1;
    assign load      = cmd_valid && (!valid_reg || out_ready);
    assign cmd_ready = load && done_inc == total;
    assign out_valid = valid_reg;
    assign out_char  = char_reg;
    assign run_last  = last_reg;

    // Emit one character per cycle from the head command while the output is not stalled.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg  <= 3'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                valid_reg <= 1'b1;
                done_reg  <= (done_inc == total) ? 3'd0 : done_inc;
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            char_reg <= (done_reg < cmd.repl_cnt) ? u2l_pkg::REPL_CHAR
                                                  : u2l_pkg::rom_lookup(cmd.code);
            last_reg <= done_inc == total;
        end
    end

    ap_done_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid |-> done_reg < total)
        else $error("emit counter past command length");
    ap_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !out_ready |=> valid_reg && $stable(char_reg))
        else $error("output changed while stalled");
    ap_idle_done: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd_valid |-> done_reg == 3'd0)
        else $error("partial command with empty queue");

endmodule
